FILE: rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and constants for the record deque with removal by key.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int OP_W    = 3;
    localparam int ID_W    = 16;
    localparam int SIZE_W  = 14;
    localparam int PRICE_W = 20;
    localparam int ST_W    = 2;
    localparam int OCC_W   = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [ID_W-1:0]    item_id;
        logic [SIZE_W-1:0]  item_size;
        logic [PRICE_W-1:0] item_price;
    } in_beat_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [ID_W-1:0]    out_id;
        logic [SIZE_W-1:0]  out_size;
        logic [PRICE_W-1:0] out_price;
        logic [OCC_W-1:0]   occupancy;
    } out_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SIZE_W-1:0]  size;
        logic [PRICE_W-1:0] price;
    } rec_t;

    // Operation broadcast to every cell; flags are already qualified
    // (fire cycle, store not full / not empty).
    typedef struct packed {
        logic            push_front;
        logic            push_back;
        logic            pop_front;
        logic            pop_back;
        logic            remove;
        logic [ID_W-1:0] key;
        rec_t            new_rec;
    } cell_ctrl_t;

    // Where a cell sits relative to the current fill level.
    typedef struct packed {
        logic occupied;
        logic is_front;
        logic is_last;
        logic at_count;
    } cell_pos_t;

endpackage

FILE: rtl/record_deque_with_key_removal.sv
// ----------------------------------------------------------------------------
// record_deque_with_key_removal
// Bounded double-ended queue of (id, size, price) records with removal of
// the first record from the front whose id matches a key.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation per beat (push front/back, pop front/back,
//   remove by id). m_* returns exactly one result beat per operation: status,
//   the record taken out (zero for pushes and misses) and the occupancy.
//   The store is a row of DEPTH cells; every cell compares its id with the
//   key at once and the row shifts by at most one place in the cycle the
//   operation executes.
//   An accepted beat waits in the operation register until the output
//   register is free, then executes and its result is registered onto m_*.
//   Throughput: one operation per cycle while m_ready stays high; the
//   operation register refills in the cycle it executes. The first-match
//   ripple along the cell row sets the cycle time.
//   Reset clears the occupancy and both valid flags; the cell contents stay
//   as they are and are never read before written.
//   When m_ready is low the finished result waits in the output register,
//   one further operation is taken and held, and s_ready then drops.
// ----------------------------------------------------------------------------
module record_deque_with_key_removal (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rdq_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rdq_pkg::out_beat_t m_data
);

    localparam int DEPTH = rdq_pkg::DEPTH;
    localparam int CNT_W = rdq_pkg::CNT_W;

    logic                      busy_reg;
    logic                      busy_next;
    rdq_pkg::in_beat_t         op_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    rdq_pkg::out_beat_t        m_data_reg;
    rdq_pkg::out_beat_t        m_data_next;

    logic                      exec;
    logic                      full;
    logic                      empty;
    rdq_pkg::cell_ctrl_t       ctrl;
    rdq_pkg::rec_t             new_rec;

    rdq_pkg::rec_t             recs  [DEPTH];
    logic                      hit   [DEPTH+1];
    logic                      take  [DEPTH+1];
    rdq_pkg::rec_t             data  [DEPTH+1];
    logic [DEPTH-1:0]          sel_vec;

    assign exec    = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready = !busy_reg || exec;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign new_rec.id    = op_reg.item_id;
    assign new_rec.size  = op_reg.item_size;
    assign new_rec.price = op_reg.item_price;

    always_comb begin
        ctrl            = '0;
        ctrl.key        = op_reg.item_id;
        ctrl.new_rec    = new_rec;
        ctrl.push_front = exec && (op_reg.opcode == rdq_pkg::OP_PUSH_FRONT) && !full;
        ctrl.push_back  = exec && (op_reg.opcode == rdq_pkg::OP_PUSH_BACK) && !full;
        ctrl.pop_front  = exec && (op_reg.opcode == rdq_pkg::OP_POP_FRONT) && !empty;
        ctrl.pop_back   = exec && (op_reg.opcode == rdq_pkg::OP_POP_BACK) && !empty;
        ctrl.remove     = exec && (op_reg.opcode == rdq_pkg::OP_REMOVE) && !empty;
    end

    assign hit[0]  = 1'b0;
    assign take[0] = 1'b0;
    assign data[0] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        rdq_pkg::cell_pos_t pos;
        rdq_pkg::rec_t      left_rec;
        rdq_pkg::rec_t      right_rec;

        assign pos.occupied = (CNT_W'(i) < count_reg);
        assign pos.is_front = (i == 0);
        assign pos.is_last  = (count_reg == CNT_W'(i + 1));
        assign pos.at_count = (count_reg == CNT_W'(i));

        if (i == 0) begin : g_head
            assign left_rec = new_rec;
        end else begin : g_body
            assign left_rec = recs[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_rec = '0;
        end else begin : g_inner
            assign right_rec = recs[i+1];
        end

        rdq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .pos       (pos),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .hit_in    (hit[i]),
            .take_in   (take[i]),
            .data_in   (data[i]),
            .rec       (recs[i]),
            .hit_out   (hit[i+1]),
            .take_out  (take[i+1]),
            .sel       (sel_vec[i]),
            .data_out  (data[i+1])
        );
    end

    always_comb begin
        count_next         = count_reg;
        m_data_next        = m_data_reg;
        m_data_next.status = rdq_pkg::ST_OK;
        m_data_next.out_id    = '0;
        m_data_next.out_size  = '0;
        m_data_next.out_price = '0;
        case (op_reg.opcode)
            rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    m_data_next.status = rdq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK, rdq_pkg::OP_REMOVE: begin
                if (take[DEPTH]) begin
                    count_next            = count_reg - CNT_W'(1);
                    m_data_next.out_id    = data[DEPTH].id;
                    m_data_next.out_size  = data[DEPTH].size;
                    m_data_next.out_price = data[DEPTH].price;
                end else begin
                    m_data_next.status = rdq_pkg::ST_EMPTY;
                end
            end
            default: begin
                // unused opcodes leave the store alone
            end
        endcase
        m_data_next.occupancy = rdq_pkg::OCC_W'(count_next);
    end

    always_comb begin
        busy_next = busy_reg;
        if (exec) begin
            busy_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            busy_next = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (exec) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            if (exec) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_data;
        end
        if (exec) begin
            m_data_reg <= m_data_next;
        end
    end

    // at most one slot leaves the row per operation
    a_one_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(sel_vec))
        else $error("more than one cell selected");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push_front || ctrl.push_back) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not add a record");

    a_take_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && take[DEPTH]) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("removal did not drop a record");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> m_valid_reg)
        else $error("executed operation gave no result");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("accepting while an operation is parked");

endmodule

FILE: rtl/rdq_cell.sv
// ----------------------------------------------------------------------------
// rdq_cell
// One slot of the deque: holds a record, matches its id against the key,
// passes hit / take / data along the chain and shifts to its neighbors.
// ----------------------------------------------------------------------------
module rdq_cell (
    input  logic                aclk,
    input  rdq_pkg::cell_ctrl_t ctrl,
    input  rdq_pkg::cell_pos_t  pos,
    input  rdq_pkg::rec_t       left_rec,
    input  rdq_pkg::rec_t       right_rec,
    input  logic                hit_in,
    input  logic                take_in,
    input  rdq_pkg::rec_t       data_in,
    output rdq_pkg::rec_t       rec,
    output logic                hit_out,
    output logic                take_out,
    output logic                sel,
    output rdq_pkg::rec_t       data_out
);

    rdq_pkg::rec_t rec_reg;
    rdq_pkg::rec_t rec_next;
    logic          match;

    assign rec = rec_reg;

    assign match = ctrl.remove && pos.occupied && (rec_reg.id == ctrl.key);

    // first match from the front wins
    assign sel = (match && !hit_in)
               || (ctrl.pop_front && pos.is_front)
               || (ctrl.pop_back && pos.is_last);

    assign hit_out  = hit_in || match;
    assign take_out = take_in || sel;
    assign data_out = sel ? (data_in | rec_reg) : data_in;

    always_comb begin
        rec_next = rec_reg;
        if (ctrl.push_front) begin
            rec_next = pos.is_front ? ctrl.new_rec : left_rec;
        end else if (ctrl.push_back) begin
            if (pos.at_count) begin
                rec_next = ctrl.new_rec;
            end
        end else if (take_out) begin
            // close the gap: everything behind the taken slot moves up
            rec_next = right_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule

FILE: bench/tb_record_deque_with_key_removal.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_record_deque_with_key_removal
// Self-checking bench for the record deque. A queue of operations feeds a
// bursty driver; a shadow deque predicts each result beat at accept time and
// a monitor checks every returned beat field by field in order, while the
// result side stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module tb_record_deque_with_key_removal;
    import rdq_pkg::*;

    localparam int N_RANDOM = 935;

    typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_t;
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_beat_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_beat_t  m_data;

    in_beat_t   pending_ops[$];
    out_beat_t  expected_results[$];
    int         n_errors = 0;

    // shadow copy of the store
    rec_t        held[DEPTH];
    int unsigned held_cnt = 0;

    record_deque_with_key_removal dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one operation to the shadow deque and return its result beat.
    function automatic out_beat_t deque_apply(in_beat_t op);
        out_beat_t r;
        rec_t      nr;
        int        pos;
        r = '0;
        pos = -1;
        nr.id = op.item_id;
        nr.size = op.item_size;
        nr.price = op.item_price;
        case (op.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (held_cnt >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (op.opcode == OP_PUSH_FRONT) begin
                        for (int k = held_cnt; k > 0; k--)
                            held[k] = held[k-1];
                        held[0] = nr;
                    end else begin
                        held[held_cnt] = nr;
                    end
                    held_cnt++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (held_cnt == 0)
                    r.status = ST_EMPTY;
                else
                    pos = (op.opcode == OP_POP_FRONT) ? 0 : held_cnt - 1;
            end
            OP_REMOVE: begin
                for (int k = 0; k < held_cnt; k++)
                    if (pos < 0 && held[k].id == op.item_id)
                        pos = k;
                if (pos < 0)
                    r.status = ST_EMPTY;
            end
            default: ;
        endcase
        if (pos >= 0) begin
            r.status = ST_OK;
            r.out_id = held[pos].id;
            r.out_size = held[pos].size;
            r.out_price = held[pos].price;
            for (int k = pos; k + 1 < held_cnt; k++)
                held[k] = held[k+1];
            held_cnt--;
        end
        r.occupancy = OCC_W'(held_cnt);
        return r;
    endfunction

    task automatic queue_op(logic [OP_W-1:0] opc, logic [ID_W-1:0] id,
                            logic [SIZE_W-1:0] sz, logic [PRICE_W-1:0] pr);
        in_beat_t b;
        b.opcode = opc;
        b.item_id = id;
        b.item_size = sz;
        b.item_price = pr;
        pending_ops.push_back(b);
    endtask

    // Mostly a small pool so removals hit and ids repeat; sometimes full range.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 3) == 0)
            return ID_W'($urandom);
        return ID_W'($urandom_range(0, 15));
    endfunction

    // sender: bursts of beats with random gaps between them
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin : drive_p
        logic     nxt_valid;
        in_beat_t nxt_data;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt_data = s_data;
            if (s_valid && s_ready) begin
                expected_results.push_back(deque_apply(s_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() > 0) begin
                    nxt_data = pending_ops.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(0, 3);
                    end
                end
            end
            s_valid <= nxt_valid;
            s_data <= nxt_data;
        end
    end

    // receiver: switches between open, a rotating stall pattern and coin flips
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [15:0] stall_pat = '1;

    always @(posedge aclk) begin : ready_p
        logic rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(8, 64);
                stall_pat = 16'($urandom);
            end
            rx_left--;
            case (rx_mode)
                RX_PATTERN: begin
                    stall_pat = {stall_pat[0], stall_pat[15:1]};
                    rdy = stall_pat[0];
                end
                RX_RANDOM: rdy = ($urandom_range(0, 3) != 0);
                default:   rdy = 1'b1;
            endcase
            m_ready <= rdy;
        end
    end

    always @(posedge aclk) begin : check_p
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result beat, expected none actual %h",
                         $time, m_data);
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                end
                if (m_data.out_id !== want.out_id) begin
                    n_errors++;
                    $display("%0t: out_id expected %h actual %h",
                             $time, want.out_id, m_data.out_id);
                end
                if (m_data.out_size !== want.out_size) begin
                    n_errors++;
                    $display("%0t: out_size expected %h actual %h",
                             $time, want.out_size, m_data.out_size);
                end
                if (m_data.out_price !== want.out_price) begin
                    n_errors++;
                    $display("%0t: out_price expected %h actual %h",
                             $time, want.out_price, m_data.out_price);
                end
                if (m_data.occupancy !== want.occupancy) begin
                    n_errors++;
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, m_data.occupancy);
                end
            end
        end
    end

    initial begin : stim_p
        op_mix_t         mix;
        int              seg_left;
        int              roll;
        logic [OP_W-1:0] opc;
        logic [SIZE_W-1:0]  sz;
        logic [PRICE_W-1:0] pr;

        // directed: empty store, unused codes, extremes, id zero, misses
        queue_op(OP_POP_FRONT, '0, '0, '0);
        queue_op(OP_POP_BACK, '1, '1, '1);
        queue_op(OP_REMOVE, '0, '0, '0);
        for (int k = OP_REMOVE + 1; k <= {OP_W{1'b1}}; k++)
            queue_op(OP_W'(k), '1, '1, '1);
        queue_op(OP_PUSH_BACK, '0, '0, '0);
        queue_op(OP_PUSH_FRONT, '1, '1, '1);
        queue_op(OP_PUSH_BACK, 16'h5a5a, 14'h2aaa, 20'h55555);
        queue_op(OP_REMOVE, '0, '1, '1);           // all-zero record, status ok
        queue_op(OP_REMOVE, 16'h1234, '0, '0);     // id not held
        queue_op(OP_POP_BACK, '0, '0, '0);
        queue_op(OP_POP_FRONT, '0, '0, '0);
        queue_op(OP_POP_FRONT, '0, '0, '0);        // empty again
        // duplicate ids: removal must take the one nearest the front
        queue_op(OP_PUSH_BACK, 16'd7, 14'd1, 20'd1);
        queue_op(OP_PUSH_BACK, 16'd7, 14'd2, 20'd2);
        queue_op(OP_PUSH_FRONT, 16'd3, 14'd3, 20'd3);
        queue_op(OP_REMOVE, 16'd7, '0, '0);
        queue_op(OP_REMOVE, 16'd7, '0, '0);
        queue_op(OP_REMOVE, 16'd3, '0, '0);

        // random: segments biased toward filling, draining or balance
        seg_left = 0;
        mix = MIX_EVEN;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (seg_left == 0) begin
                mix = op_mix_t'($urandom_range(0, 2));
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  opc = (roll < 75) ? OP_PUSH_BACK : (roll < 88) ? OP_POP_FRONT
                               : (roll < 97) ? OP_REMOVE : OP_W'($urandom);
                MIX_DRAIN: opc = (roll < 15) ? OP_PUSH_FRONT : (roll < 70) ? OP_POP_BACK
                               : (roll < 97) ? OP_REMOVE : OP_W'($urandom);
                default:   opc = (roll < 45) ? OP_PUSH_FRONT : (roll < 70) ? OP_POP_FRONT
                               : (roll < 95) ? OP_REMOVE : OP_W'($urandom);
            endcase
            // swap ends half the time so every opcode shows up in every mix
            if ($urandom_range(0, 1) == 0) begin
                if (opc == OP_PUSH_BACK) opc = OP_PUSH_FRONT;
                else if (opc == OP_PUSH_FRONT) opc = OP_PUSH_BACK;
                else if (opc == OP_POP_BACK) opc = OP_POP_FRONT;
                else if (opc == OP_POP_FRONT) opc = OP_POP_BACK;
            end
            roll = $urandom_range(0, 9);
            sz = (roll == 0) ? '0 : (roll == 1) ? '1 : SIZE_W'($urandom);
            pr = (roll == 0) ? '0 : (roll == 2) ? '1 : PRICE_W'($urandom);
            queue_op(opc, pick_id(), sz, pr);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() > 0 || s_valid) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog_p
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rdq_pkg.sv
rtl/rdq_cell.sv
rtl/record_deque_with_key_removal.sv
bench/tb_record_deque_with_key_removal.sv
